// ===== rtl/core/bpenv_pkg.sv =====
// Shared constants and types for the breakpoint envelope generator.
package bpenv_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [31:0] id;
        logic [30:0] ptime;
        logic [31:0] value;
    } entry_t;

endpackage

// ===== rtl/core/breakpoint_envelope_generator.sv =====
// Breakpoint envelope generator: sorted point table in one memory, sequenced walks.
// Add shifts later points up one slot, walking down from the end, and remove compacts
// the table over every stored point. Sample seeks and advances a cursor over the entries,
// and an interpolation runs a serial shift-add multiply and then a restoring divide.
// One transaction in flight; the next is taken while a result waits at the output.
// Synchronous active-low reset empties the table and invalidates the cursor.
module breakpoint_envelope_generator #(
    parameter int MAX_POINTS = bpenv_pkg::MAX_POINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    // point_id[31:0], point_time[62:32], point_value[94:63], sample start[126:95],
    // sample end[157:127], zero fill
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cv_value[31:0], status[32], zero fill
    output logic [39:0]  m_tdata
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_POINTS);
    localparam logic [CW-1:0] CONE = CW'(1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ADD_RD  = 4'd1;
    localparam logic [3:0] ST_ADD_EV  = 4'd2;
    localparam logic [3:0] ST_ADD_INS = 4'd3;
    localparam logic [3:0] ST_REM_RD  = 4'd4;
    localparam logic [3:0] ST_REM_EV  = 4'd5;
    localparam logic [3:0] ST_SEEK_RD = 4'd6;
    localparam logic [3:0] ST_SEEK_EV = 4'd7;
    localparam logic [3:0] ST_FETCH   = 4'd8;
    localparam logic [3:0] ST_ONE_EV  = 4'd9;
    localparam logic [3:0] ST_LO_EV   = 4'd10;
    localparam logic [3:0] ST_HI_EV   = 4'd11;
    localparam logic [3:0] ST_MUL     = 4'd12;
    localparam logic [3:0] ST_DIV     = 4'd13;
    localparam logic [3:0] ST_ADV_RD  = 4'd14;
    localparam logic [3:0] ST_ADV_EV  = 4'd15;

    bpenv_pkg::entry_t mem [MAX_POINTS];
    bpenv_pkg::entry_t rd_data_reg;
    bpenv_pkg::entry_t wr_data;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic          curv_reg, curv_next;
    logic [30:0]   last_end_reg, last_end_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic [31:0]   id_reg, id_next;
    logic [30:0]   ptime_reg, ptime_next;
    logic [31:0]   pval_reg, pval_next;
    logic [31:0]   start_reg, start_next;
    logic [30:0]   end_reg, end_next;
    logic [30:0]   t1_reg, t1_next;
    logic [31:0]   v1_reg, v1_next;
    logic [30:0]   span_reg, span_next;
    logic [32:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [63:0]   prod_reg, prod_next;
    logic [31:0]   rem_reg, rem_next;
    logic [5:0]    step_reg, step_next;
    logic          fin_reg, fin_next;
    logic [31:0]   res_value_reg, res_value_next;
    logic          res_status_reg, res_status_next;
    logic          done_reg, done_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_value_reg, m_value_next;
    logic          m_status_reg, m_status_next;

    logic [30:0] span_c;
    logic [32:0] numr_c;
    logic [32:0] diff_c;
    logic [33:0] upper_c;
    logic [31:0] shl_c;
    logic        qbit_c;
    logic [33:0] qs_c;
    logic [33:0] sum_c;

    assign s_tready = (state_reg == ST_IDLE) && !done_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_status_reg, m_value_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        span_c  = rd_data_reg.ptime - t1_reg;
        numr_c  = $signed(start_reg) - $signed({2'b00, t1_reg});
        diff_c  = $signed({rd_data_reg.value[31], rd_data_reg.value})
                - $signed({v1_reg[31], v1_reg});
        upper_c = {1'b0, prod_reg[63:31]} + (prod_reg[0] ? {1'b0, mag_reg} : 34'd0);
        shl_c   = {rem_reg[30:0], prod_reg[63]};
        qbit_c  = (shl_c >= {1'b0, span_reg});
        qs_c    = neg_reg ? (34'd0 - prod_reg[33:0]) : prod_reg[33:0];
        sum_c   = {{2{v1_reg[31]}}, v1_reg} + qs_c;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        curv_next       = curv_reg;
        last_end_next   = last_end_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        id_next         = id_reg;
        ptime_next      = ptime_reg;
        pval_next       = pval_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        t1_next         = t1_reg;
        v1_next         = v1_reg;
        span_next       = span_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        fin_next        = 1'b0;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        done_next       = done_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        rd_addr         = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = '{id: id_reg, ptime: ptime_reg, value: pval_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (done_reg && (!m_valid_reg || m_tready)) begin
            m_valid_next  = 1'b1;
            m_value_next  = res_value_reg;
            m_status_next = res_status_reg;
            done_next     = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    id_next         = s_tdata[31:0];
                    ptime_next      = s_tdata[62:32];
                    pval_next       = s_tdata[94:63];
                    start_next      = s_tdata[126:95];
                    end_next        = s_tdata[157:127];
                    res_value_next  = 32'd0;
                    res_status_next = bpenv_pkg::STATUS_OK;
                    case (s_tuser)
                        bpenv_pkg::ACT_ADD: begin
                            curv_next = 1'b0;
                            cur_next  = '0;
                            if (count_reg >= CMAX) begin
                                res_status_next = bpenv_pkg::STATUS_FULL;
                                done_next       = 1'b1;
                            end else if (count_reg == '0) begin
                                idx_next   = '0;
                                state_next = ST_ADD_INS;
                            end else begin
                                idx_next   = count_reg - CONE;
                                state_next = ST_ADD_RD;
                            end
                        end
                        bpenv_pkg::ACT_REMOVE: begin
                            curv_next  = 1'b0;
                            cur_next   = '0;
                            idx_next   = '0;
                            keep_next  = '0;
                            state_next = ST_REM_RD;
                        end
                        bpenv_pkg::ACT_SAMPLE: begin
                            if (s_tdata[126]) begin
                                curv_next = 1'b0;
                                cur_next  = '0;
                                done_next = 1'b1;
                            end else if (count_reg == '0) begin
                                last_end_next = s_tdata[157:127];
                                done_next     = 1'b1;
                            end else if (!curv_reg
                                         || s_tdata[126:95] != {1'b0, last_end_reg}) begin
                                cur_next   = '0;
                                state_next = ST_SEEK_RD;
                            end else begin
                                state_next = ST_FETCH;
                            end
                        end
                        default: begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADD_RD: begin
                state_next = ST_ADD_EV;
            end
            ST_ADD_EV: begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg + CONE);
                if (rd_data_reg.ptime >= ptime_reg) begin
                    wr_data = rd_data_reg;
                    if (idx_reg == '0) begin
                        state_next = ST_ADD_INS;
                    end else begin
                        idx_next   = idx_reg - CONE;
                        state_next = ST_ADD_RD;
                    end
                end else begin
                    count_next = count_reg + CONE;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_INS: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                count_next = count_reg + CONE;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REM_RD: begin
                if (idx_reg == count_reg) begin
                    count_next = keep_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_REM_EV;
                end
            end
            ST_REM_EV: begin
                if (rd_data_reg.id != id_reg) begin
                    wr_en     = 1'b1;
                    wr_addr   = keep_reg[AW-1:0];
                    wr_data   = rd_data_reg;
                    keep_next = keep_reg + CONE;
                end
                idx_next   = idx_reg + CONE;
                state_next = ST_REM_RD;
            end
            ST_SEEK_RD: begin
                rd_addr = cur_reg[AW-1:0];
                if (cur_reg == count_reg) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_SEEK_EV;
                end
            end
            ST_SEEK_EV: begin
                if ({1'b0, rd_data_reg.ptime} < start_reg) begin
                    cur_next   = cur_reg + CONE;
                    state_next = ST_SEEK_RD;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (cur_reg == '0) begin
                    rd_addr    = '0;
                    state_next = ST_ONE_EV;
                end else if (cur_reg == count_reg) begin
                    rd_addr    = AW'(count_reg - CONE);
                    state_next = ST_ONE_EV;
                end else begin
                    rd_addr    = AW'(cur_reg - CONE);
                    state_next = ST_LO_EV;
                end
            end
            ST_ONE_EV: begin
                res_value_next = rd_data_reg.value;
                state_next     = ST_ADV_RD;
            end
            ST_LO_EV: begin
                t1_next    = rd_data_reg.ptime;
                v1_next    = rd_data_reg.value;
                rd_addr    = cur_reg[AW-1:0];
                state_next = ST_HI_EV;
            end
            ST_HI_EV: begin
                if (span_c == '0) begin
                    res_value_next = v1_reg;
                    state_next     = ST_ADV_RD;
                end else begin
                    span_next = span_c;
                    neg_next  = diff_c[32];
                    mag_next  = diff_c[32] ? (33'd0 - diff_c) : diff_c;
                    if (numr_c[32]) begin
                        prod_next = 64'd0;
                    end else if (numr_c > {2'b00, span_c}) begin
                        prod_next = {33'd0, span_c};
                    end else begin
                        prod_next = {33'd0, numr_c[30:0]};
                    end
                    step_next  = 6'd30;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next = {upper_c, prod_reg[30:1]};
                step_next = step_reg - 6'd1;
                if (step_reg == '0) begin
                    rem_next   = '0;
                    step_next  = 6'd63;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (fin_reg) begin
                    res_value_next = sum_c[31:0];
                    state_next     = ST_ADV_RD;
                end else begin
                    rem_next  = qbit_c ? (shl_c - {1'b0, span_reg}) : shl_c;
                    prod_next = {prod_reg[62:0], qbit_c};
                    step_next = step_reg - 6'd1;
                    fin_next  = (step_reg == '0);
                end
            end
            ST_ADV_RD: begin
                rd_addr = cur_reg[AW-1:0];
                if (cur_reg == count_reg) begin
                    curv_next     = 1'b1;
                    last_end_next = end_reg;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_ADV_EV;
                end
            end
            ST_ADV_EV: begin
                if (rd_data_reg.ptime < end_reg) begin
                    cur_next   = cur_reg + CONE;
                    state_next = ST_ADV_RD;
                end else begin
                    curv_next     = 1'b1;
                    last_end_next = end_reg;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cur_reg      <= '0;
            curv_reg     <= 1'b0;
            last_end_reg <= '0;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            fin_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            curv_reg     <= curv_next;
            last_end_reg <= last_end_next;
            done_reg     <= done_next;
            m_valid_reg  <= m_valid_next;
            fin_reg      <= fin_next;
        end
        idx_reg        <= idx_next;
        keep_reg       <= keep_next;
        id_reg         <= id_next;
        ptime_reg      <= ptime_next;
        pval_reg       <= pval_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        t1_reg         <= t1_next;
        v1_reg         <= v1_next;
        span_reg       <= span_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the breakpoint envelope generator.
module tb;

    localparam int NPTS = bpenv_pkg::MAX_POINTS_DEF;

    typedef struct packed {
        logic [31:0] cv;
        logic        status;
    } cv_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [159:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    breakpoint_envelope_generator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // envelope table mirror
    logic [30:0] tbl_time [NPTS];
    logic [31:0] tbl_val  [NPTS];
    logic [31:0] tbl_id   [NPTS];
    int          tbl_count;
    int          cur_pos;
    bit          cur_ok;
    logic [30:0] prev_end;

    cv_result_t  cv_expected[$];
    int          errors;
    int          rx_hold;
    int          rx_pct;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint lerp_value(int lo, longint st);
        longint t1, t2, v1, v2, span, num;
        t1 = longint'(tbl_time[lo]);
        t2 = longint'(tbl_time[lo + 1]);
        v1 = longint'($signed(tbl_val[lo]));
        v2 = longint'($signed(tbl_val[lo + 1]));
        span = t2 - t1;
        num = st - t1;
        if (span <= 0) return v1;
        if (num < 0) num = 0;
        if (num > span) num = span;
        return v1 + ((v2 - v1) * num) / span;
    endfunction

    function automatic cv_result_t envelope_step(logic [1:0] act, logic [31:0] pid,
            logic [30:0] ptm, logic [31:0] pval, logic [31:0] st_raw, logic [30:0] en);
        cv_result_t r;
        longint v, st;
        int pos, keep;
        r = '0;
        r.status = bpenv_pkg::STATUS_OK;
        v = 0;
        st = longint'($signed(st_raw));
        case (act)
            bpenv_pkg::ACT_ADD: begin
                if (tbl_count >= NPTS) begin
                    r.status = bpenv_pkg::STATUS_FULL;
                end else begin
                    pos = 0;
                    while (pos < tbl_count && tbl_time[pos] < ptm) pos++;
                    for (int i = tbl_count; i > pos; i--) begin
                        tbl_time[i] = tbl_time[i-1];
                        tbl_val[i]  = tbl_val[i-1];
                        tbl_id[i]   = tbl_id[i-1];
                    end
                    tbl_time[pos] = ptm;
                    tbl_val[pos]  = pval;
                    tbl_id[pos]   = pid;
                    tbl_count++;
                end
                cur_ok = 0;
                cur_pos = 0;
            end
            bpenv_pkg::ACT_REMOVE: begin
                keep = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_id[i] != pid) begin
                        tbl_time[keep] = tbl_time[i];
                        tbl_val[keep]  = tbl_val[i];
                        tbl_id[keep]   = tbl_id[i];
                        keep++;
                    end
                end
                tbl_count = keep;
                cur_ok = 0;
                cur_pos = 0;
            end
            bpenv_pkg::ACT_SAMPLE: begin
                if (st < 0) begin
                    cur_ok = 0;
                    cur_pos = 0;
                end else begin
                    if (tbl_count > 0) begin
                        if (!cur_ok || st != longint'(prev_end)) begin
                            cur_pos = 0;
                            while (cur_pos < tbl_count && longint'(tbl_time[cur_pos]) < st)
                                cur_pos++;
                        end
                        if (cur_pos == 0) v = longint'($signed(tbl_val[0]));
                        else if (cur_pos < tbl_count) v = lerp_value(cur_pos - 1, st);
                        else v = longint'($signed(tbl_val[tbl_count - 1]));
                        while (cur_pos < tbl_count && tbl_time[cur_pos] < en) cur_pos++;
                        cur_ok = 1;
                    end
                    prev_end = en;
                end
            end
            default: ;
        endcase
        r.cv = v[31:0];
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(logic [1:0] act, logic [31:0] pid, logic [30:0] ptm,
            logic [31:0] pval, logic [31:0] st, logic [30:0] en);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tuser  <= act;
        s_tdata  <= {2'b00, en, st, pval, ptm, pid};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cv_expected.push_back(envelope_step(act, pid, ptm, pval, st, en));
        @(negedge aclk);
    endtask

    // checker
    always @(posedge aclk) begin
        cv_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[32]};
            if (cv_expected.size() == 0) begin
                $display("%0t: unexpected result cv=%h status=%b", $time, got.cv, got.status);
                errors++;
            end else begin
                exp_r = cv_expected.pop_front();
                if (got.cv !== exp_r.cv) begin
                    $display("%0t: cv_value expected %h actual %h", $time, exp_r.cv, got.cv);
                    errors++;
                end
                if (got.status !== exp_r.status) begin
                    $display("%0t: status expected %b actual %b",
                        $time, exp_r.status, got.status);
                    errors++;
                end
            end
        end
    end

    // result back-pressure, mostly short gaps with an occasional long stall
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) == 0) begin
            rx_hold  <= $urandom_range(10, 60);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    function automatic logic [30:0] rnd_t31();
        return 31'($urandom());
    endfunction

    task automatic add_pt(logic [31:0] pid, logic [30:0] t, logic [31:0] v);
        send_item(bpenv_pkg::ACT_ADD, pid, t, v, $urandom(), rnd_t31());
    endtask

    task automatic sample_at(logic [31:0] st, logic [30:0] en);
        send_item(bpenv_pkg::ACT_SAMPLE, $urandom(), rnd_t31(), $urandom(), st, en);
    endtask

    task automatic test_directed();
        sample_at(32'd0, 31'd10);
        sample_at(32'h8000_0000, 31'd5);
        add_pt(32'hffff_ffff, 31'd100, 32'h7fff_ffff);
        add_pt(32'd0, 31'd200, 32'h8000_0000);
        add_pt(32'd7, 31'd100, 32'h0001_0000);
        add_pt(32'd8, 31'h7fff_ffff, 32'h1234_5678);
        sample_at(32'd0, 31'd50);
        sample_at(32'd50, 31'd150);
        sample_at(32'd150, 31'd120);
        sample_at(32'd120, 31'd300);
        sample_at(32'd250, 31'h7fff_ffff);
        sample_at(32'h7fff_ffff, 31'h7fff_ffff);
        sample_at(32'hffff_ffff, 31'd0);
        send_item(bpenv_pkg::ACT_NOP, 32'd7, 31'd1, 32'd1, 32'd1, 31'd1);
        send_item(bpenv_pkg::ACT_REMOVE, 32'd7, 31'd0, 32'd0, 32'd0, 31'd0);
        sample_at(32'd150, 31'd160);
        send_item(bpenv_pkg::ACT_REMOVE, 32'hffff_ffff, 31'd0, 32'd0, 32'd0, 31'd0);
        send_item(bpenv_pkg::ACT_REMOVE, 32'd0, 31'd0, 32'd0, 32'd0, 31'd0);
        send_item(bpenv_pkg::ACT_REMOVE, 32'd8, 31'd0, 32'd0, 32'd0, 31'd0);
        sample_at(32'd10, 31'd20);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NPTS + 2; i++)
            add_pt(i % 3, 31'($urandom_range(0, 1000)), $urandom());
        sample_at(32'd500, 31'd600);
        for (int i = 0; i < 3; i++)
            send_item(bpenv_pkg::ACT_REMOVE, i, 31'd0, 32'd0, 32'd0, 31'd0);
    endtask

    task automatic test_random(int n);
        int k;
        logic [31:0] st;
        logic [30:0] en;
        st = 0;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 22) begin
                add_pt($urandom_range(0, 7), $urandom_range(0, 1) ? rnd_t31()
                       : 31'($urandom_range(0, 5000)), $urandom());
            end else if (k < 28) begin
                send_item(bpenv_pkg::ACT_REMOVE, ($urandom_range(0, 9) == 0) ? $urandom()
                          : $urandom_range(0, 7), rnd_t31(), $urandom(), $urandom(), rnd_t31());
            end else if (k < 30) begin
                send_item(bpenv_pkg::ACT_NOP, $urandom(), rnd_t31(), $urandom(), $urandom(),
                          rnd_t31());
            end else if (k < 34) begin
                sample_at($urandom() | 32'h8000_0000, rnd_t31());
            end else if (k < 40) begin
                st = $urandom() & 32'h7fff_ffff;
                en = rnd_t31();
                sample_at(st, en);
                st = {1'b0, en};
            end else begin
                // contiguous playback
                en = st[30:0] + 31'($urandom_range(0, 200));
                if ($urandom_range(0, 19) == 0) st = $urandom_range(0, 5000);
                sample_at(st, en);
                st = {1'b0, en};
            end
        end
    endtask

    initial begin
        errors = 0;
        tbl_count = 0;
        cur_pos = 0;
        cur_ok = 0;
        prev_end = '0;
        rx_hold = 0;
        rx_pct = 100;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        rx_pct = 70;
        test_full_table();
        test_random(500);
        rx_pct = 100;
        test_random(300);
        rx_pct = 40;
        test_random(500);
        rx_pct = 85;
        test_random(400);
        s_tvalid <= 1'b0;
        while (cv_expected.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
